// ----- design/cliq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cliq_pkg
// Shared types and constants of the credit limited interrupt queue: request
// action codes, register indexes, register reset values and the control and
// status bundles passed between the queue, credit and top-level logic.
// ----------------------------------------------------------------------------
package cliq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 128;

   localparam int VECTOR_W   = 8;
   localparam int CFG_W      = 16;
   localparam int CREDIT_W   = 17;
   localparam int PENDING_W  = 8;
   localparam int CSR_IDX_W  = 2;

   // request actions
   localparam logic ACTION_STEP  = 1'b0;
   localparam logic ACTION_RAISE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CREDITS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CREDIT_INCREMENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INJECTION_COST   = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] MAX_CREDITS_RESET      = 16'd16;
   localparam logic [CFG_W-1:0] CREDIT_INCREMENT_RESET = 16'd1;
   localparam logic [CFG_W-1:0] INJECTION_COST_RESET   = 16'd4;

   typedef struct packed {
      logic                push;
      logic                pop;
      logic [VECTOR_W-1:0] push_data;
   } fifo_ctrl_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [VECTOR_W-1:0] head_data;
   } fifo_status_type;

   typedef struct packed {
      logic                inject;
      logic                window;
      logic [CREDIT_W-1:0] credits_next;
   } credit_result_type;

endpackage

`default_nettype wire

// ----- design/cliq_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cliq_fifo
// Circular queue of pending interrupt vectors with head and tail pointers and
// an entry count. The next head entry is read ahead into a register,
// with a bypass for a write to the slot that becomes the head.
// ----------------------------------------------------------------------------
module cliq_fifo #(
   parameter int QUEUE_DEPTH = cliq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire                        clock,
   input  wire                        reset,
   input  cliq_pkg::fifo_ctrl_type    ctrl,
   output cliq_pkg::fifo_status_type  status,
   output logic [CNT_W-1:0]           count_next
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [cliq_pkg::VECTOR_W-1:0] mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]              head_ff, head_in;
   logic [PTR_W-1:0]              tail_ff, tail_in;
   logic [CNT_W-1:0]              count_ff;
   logic [cliq_pkg::VECTOR_W-1:0] head_data_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      end
      if (ctrl.push) begin
         tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      end
   end

   always_comb begin
      case ({ctrl.push, ctrl.pop})
         2'b10:   count_next = count_ff + 1'b1;
         2'b01:   count_next = count_ff - 1'b1;
         default: count_next = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_next;
      end
   end

   // storage write and head prefetch
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= ctrl.push_data;
      end
      if (ctrl.push && (tail_ff == head_in)) begin
         head_data_ff <= ctrl.push_data;
      end else begin
         head_data_ff <= mem[head_in];
      end
   end

   assign status.empty     = (count_ff == '0);
   assign status.full      = (count_ff == CNT_FULL);
   assign status.head_data = head_data_ff;

endmodule

`default_nettype wire

// ----- design/cliq_credit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cliq_credit
// Credit counter with refill below the ceiling, and the injection decision:
// inject when vectors are pending, the processor is ready and the credits
// cover the cost; request a window when the processor is not ready.
// ----------------------------------------------------------------------------
module cliq_credit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                step_en,
   input  wire                                pending,
   input  wire                                cpu_ready,
   input  wire  [cliq_pkg::CFG_W-1:0]         max_credits,
   input  wire  [cliq_pkg::CFG_W-1:0]         credit_increment,
   input  wire  [cliq_pkg::CFG_W-1:0]         injection_cost,
   output cliq_pkg::credit_result_type        result
);

   logic [cliq_pkg::CREDIT_W-1:0] credit_ff;
   logic [cliq_pkg::CREDIT_W-1:0] refilled;
   logic                          can_pay;

   always_comb begin
      refilled = credit_ff;
      if (credit_ff < cliq_pkg::CREDIT_W'(max_credits)) begin
         refilled = credit_ff + cliq_pkg::CREDIT_W'(credit_increment);
      end
      can_pay = (refilled >= cliq_pkg::CREDIT_W'(injection_cost));
   end

   always_comb begin
      result.inject       = step_en && pending && cpu_ready && can_pay;
      result.window       = step_en && pending && !cpu_ready;
      result.credits_next = credit_ff;
      if (step_en) begin
         result.credits_next = result.inject
            ? refilled - cliq_pkg::CREDIT_W'(injection_cost) : refilled;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= cliq_pkg::CREDIT_W'(cliq_pkg::MAX_CREDITS_RESET);
      end else begin
         credit_ff <= result.credits_next;
      end
   end

endmodule

`default_nettype wire

// ----- design/credit_limited_interrupt_queue_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// credit_limited_interrupt_queue_unit
// Interrupt injector: raise requests queue vectors, step requests refill a
// credit counter and inject the oldest vector when credits and cpu_ready allow.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, vector, cpu_ready
//   rsp      out        rsp_valid/rsp_stall  inject, vector, window, overflow,
//                                            pending count, credits
//   csr      in         csr_write_enable     index, 16-bit write data
//
// One request per cycle sustained while no valid result is held by rsp_stall;
// each request is taken into the input register, which feeds the result register.
// The rate is set by the single credit add-compare-subtract and one queue
// access per cycle. Reset is synchronous; registers return to defaults,
// credits load 16, the queue empties at once with no clearing pass.
// rsp_stall holds the result register and stalls req once the input register
// is occupied.
// ----------------------------------------------------------------------------
module credit_limited_interrupt_queue_unit #(
   parameter int QUEUE_DEPTH = cliq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire                                 req_action,
   input  wire  [cliq_pkg::VECTOR_W-1:0]       req_vector,
   input  wire                                 req_cpu_ready,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_inject_valid,
   output logic [cliq_pkg::VECTOR_W-1:0]       rsp_injected_vector,
   output logic                                rsp_window_request,
   output logic                                rsp_overflow,
   output logic [cliq_pkg::PENDING_W-1:0]      rsp_pending_count,
   output logic [cliq_pkg::CREDIT_W-1:0]       rsp_credits_now,
   input  wire                                 csr_write_enable,
   input  wire  [cliq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [cliq_pkg::CFG_W-1:0]          csr_write_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [cliq_pkg::CFG_W-1:0]    max_credits_ff;
   logic [cliq_pkg::CFG_W-1:0]    credit_increment_ff;
   logic [cliq_pkg::CFG_W-1:0]    injection_cost_ff;

   logic                          in_valid_ff;
   logic                          in_action_ff;
   logic [cliq_pkg::VECTOR_W-1:0] in_vector_ff;
   logic                          in_cpu_ready_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_inject_ff;
   logic [cliq_pkg::VECTOR_W-1:0] rsp_vector_ff;
   logic                          rsp_window_ff;
   logic                          rsp_overflow_ff;
   logic [cliq_pkg::PENDING_W-1:0] rsp_pending_ff;
   logic [cliq_pkg::CREDIT_W-1:0] rsp_credits_ff;

   logic                          advance;
   logic                          process;
   logic                          is_raise;
   logic                          overflow;

   cliq_pkg::fifo_ctrl_type       fifo_ctrl;
   cliq_pkg::fifo_status_type     fifo_status;
   cliq_pkg::credit_result_type   credit_result;
   logic [CNT_W-1:0]              count_next;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_credits_ff      <= cliq_pkg::MAX_CREDITS_RESET;
         credit_increment_ff <= cliq_pkg::CREDIT_INCREMENT_RESET;
         injection_cost_ff   <= cliq_pkg::INJECTION_COST_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            cliq_pkg::CSR_MAX_CREDITS:      max_credits_ff      <= csr_write_data;
            cliq_pkg::CSR_CREDIT_INCREMENT: credit_increment_ff <= csr_write_data;
            cliq_pkg::CSR_INJECTION_COST:   injection_cost_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff    <= req_action;
         in_vector_ff    <= req_vector;
         in_cpu_ready_ff <= req_cpu_ready;
      end
   end

   assign is_raise = (in_action_ff == cliq_pkg::ACTION_RAISE);
   assign overflow = process && is_raise && fifo_status.full;

   assign fifo_ctrl.push      = process && is_raise && !fifo_status.full;
   assign fifo_ctrl.pop       = credit_result.inject;
   assign fifo_ctrl.push_data = in_vector_ff;

   cliq_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (fifo_ctrl),
      .status     (fifo_status),
      .count_next (count_next)
   );

   cliq_credit u_credit (
      .clock            (clock),
      .reset            (reset),
      .step_en          (process && (in_action_ff == cliq_pkg::ACTION_STEP)),
      .pending          (!fifo_status.empty),
      .cpu_ready        (in_cpu_ready_ff),
      .max_credits      (max_credits_ff),
      .credit_increment (credit_increment_ff),
      .injection_cost   (injection_cost_ff),
      .result           (credit_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_inject_ff   <= credit_result.inject;
         rsp_vector_ff   <= credit_result.inject ? fifo_status.head_data : '0;
         rsp_window_ff   <= credit_result.window;
         rsp_overflow_ff <= overflow;
         rsp_pending_ff  <= cliq_pkg::PENDING_W'(count_next);
         rsp_credits_ff  <= credit_result.credits_next;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inject_valid    = rsp_inject_ff;
   assign rsp_injected_vector = rsp_vector_ff;
   assign rsp_window_request  = rsp_window_ff;
   assign rsp_overflow        = rsp_overflow_ff;
   assign rsp_pending_count   = rsp_pending_ff;
   assign rsp_credits_now     = rsp_credits_ff;

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_inject_valid && (rsp_window_request || rsp_overflow)))
      else $error("inject flagged together with window or overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_next <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      credit_result.inject |-> !fifo_status.empty && !fifo_ctrl.push)
      else $error("pop from empty queue or with push");

   a_credits_idle: assert property (@(posedge clock) disable iff (reset)
      !process |-> credit_result.credits_next == $past(credit_result.credits_next)
                   || $past(reset))
      else $error("credits changed without a request");
`endif

endmodule

`default_nettype wire
